// ===== design/density_clustering_3d_defines.svh =====
// Assertion helpers for the clustering block
`ifndef DENSITY_CLUSTERING_3D_DEFINES_SVH
`define DENSITY_CLUSTERING_3D_DEFINES_SVH

`define DC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dc check failed");

`define DC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dc check failed");

`endif

// ===== design/dc3d_pkg.sv =====
`timescale 1ns / 1ps
package dc3d_pkg;
    localparam int DefMaxPoints = 1024;
    localparam int DefCoordBits = 16;
    localparam int CntW = 11;
    localparam int ThrW = 34;
    localparam int LblW = 11;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_POINT_COUNT = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_MIN_NEIGH   = 2'd2,
        REG_NORM        = 2'd3
    } reg_index_t;

    localparam logic [1:0] NORM_L1    = 2'd0;
    localparam logic [1:0] NORM_L2    = 2'd1;
    localparam logic [1:0] NORM_CHEB  = 2'd2;
    localparam logic [1:0] NORM_SPARE = 2'd3;

    localparam logic signed [LblW-1:0] LBL_NOISE = -11'sd2;
    localparam logic signed [LblW-1:0] LBL_UNCL  = -11'sd1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLEAR, S_OUTER, S_OUTER_RD, S_PT_RD, S_PT_WAIT,
        S_CNT, S_CNT_DRAIN, S_DECIDE, S_MARK, S_MARK_DRAIN,
        S_Q_RD, S_Q_WAIT, S_GROW, S_GROW_DRAIN, S_NEXT, S_DONE,
        S_RD_WAIT, S_OUT
    } state_t;
endpackage

// ===== design/dc3d_stream_if.sv =====
`timescale 1ns / 1ps
interface dc3d_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/density_clustering_3d.sv =====
`timescale 1ns / 1ps
// DBSCAN over up to MAX_POINTS 3D points held in block RAM. After reset the
// label RAM is swept to unclassified before the first item is taken. Load
// items are taken back to back, also while a result waits; a read item goes
// through S_RD_WAIT and S_OUT to the output register, and waits in S_OUT
// while an earlier result is still waiting. A run first sweeps the label RAM
// to unclassified, then for every core test and every relabel pass streams
// all point_count points (at most MAX_POINTS) through a two-stage distance
// pipe, one point a cycle. No item is taken during a run.
module density_clustering_3d
    import dc3d_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints,
    parameter int COORD_BITS = DefCoordBits
) (
    input  logic          clk,
    input  logic          rst_n,
    dc3d_stream_if.sink   in_ch,
    dc3d_stream_if.source out_ch,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [ThrW-1:0] cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = 3 * COORD_BITS;
    localparam int NW = AW + 1;

    logic [CntW-1:0] pcount_reg;
    logic [ThrW-1:0] thr_reg;
    logic [CntW-1:0] minn_reg;
    logic [1:0]      norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
            thr_reg    <= '0;
            minn_reg   <= CntW'(4);
            norm_reg   <= NORM_L2;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_POINT_COUNT: pcount_reg <= cfg_data[CntW-1:0];
                REG_THRESHOLD:   thr_reg    <= cfg_data;
                REG_MIN_NEIGH:   minn_reg   <= cfg_data[CntW-1:0];
                default:         norm_reg   <= cfg_data[1:0];
            endcase
        end
    end

    // input unpack
    logic [1:0]  in_op;
    logic [9:0]  in_idx;
    logic [PW-1:0] in_pt;
    assign in_op  = in_ch.data[1:0];
    assign in_idx = in_ch.data[11:2];
    assign in_pt  = {in_ch.data[44 +: COORD_BITS], in_ch.data[28 +: COORD_BITS],
                     in_ch.data[12 +: COORD_BITS]};

    // memories
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic [PW-1:0] p_rd;
    logic          l_we;
    logic [AW-1:0] l_wa, l_ra;
    logic [LblW-1:0] l_wd, l_rd;
    logic          q_we;
    logic [AW-1:0] q_wa, q_ra;
    logic [AW-1:0] q_rd;

    dc3d_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(in_pt), .raddr(p_ra), .rdata(p_rd));
    dc3d_ram #(.WIDTH(LblW), .DEPTH(MAX_POINTS)) u_labels (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    dc3d_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(l_wa), .raddr(q_ra), .rdata(q_rd));

    state_t state_reg, state_next;
    logic [NW-1:0] n_reg;          // saturated point count
    logic [NW-1:0] i_reg, i_next;  // outer index / clear index
    logic [NW-1:0] j_reg, j_next;  // scan index
    logic [AW-1:0] cur_reg, cur_next;
    logic [PW-1:0] cpt_reg, cpt_next;
    logic [NW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CntW-1:0] cid_reg, cid_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic          seed_reg, seed_next;  // expanding from the seed point itself
    logic          outv_reg, outv_next;
    logic signed [LblW-1:0] olbl_reg, olbl_next;
    logic [CntW-1:0] occ_reg, occ_next;
    logic [AW-1:0] rdidx_reg, rdidx_next;
    logic          rdoor_reg, rdoor_next;

    // distance pipe: j_reg -> registered p_rd -> registered u_dist -> hit
    logic          hit;
    logic          v1_reg, v2_reg, v1_next;
    logic [AW-1:0] j1_reg, j2_reg;
    logic [LblW-1:0] l2_reg;

    dc3d_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .clk(clk), .pa(cpt_reg), .pb(p_rd), .norm(norm_reg), .thr(thr_reg), .hit(hit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            i_reg <= '0; j_reg <= '0; head_reg <= '0; tail_reg <= '0;
            cid_reg <= '0; cnt_reg <= '0; seed_reg <= 1'b0; outv_reg <= 1'b0;
            v1_reg <= 1'b0; v2_reg <= 1'b0; n_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next; j_reg <= j_next; head_reg <= head_next;
            tail_reg <= tail_next; cid_reg <= cid_next; cnt_reg <= cnt_next;
            seed_reg <= seed_next; outv_reg <= outv_next;
            v1_reg <= v1_next; v2_reg <= v1_reg;
            if (state_reg == S_IDLE)
            begin
                n_reg <= (pcount_reg > CntW'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                          : NW'(pcount_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; cpt_reg <= cpt_next; olbl_reg <= olbl_next;
        occ_reg <= occ_next; rdidx_reg <= rdidx_next; rdoor_reg <= rdoor_next;
        j1_reg <= j_reg[AW-1:0]; j2_reg <= j1_reg; l2_reg <= l_rd;
    end

    logic scanning;
    logic scan_last;
    logic out_free;
    assign scanning  = (state_reg == S_CNT) || (state_reg == S_MARK) ||
                       (state_reg == S_GROW);
    assign scan_last = (j_reg + NW'(1)) >= n_reg;
    // the output register is free, or its item leaves at this edge
    assign out_free  = !outv_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:       state_next = (i_reg == NW'(MAX_POINTS - 1)) ? S_IDLE : S_INIT;
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (opcode_t'(in_op))
                        OP_RUN:  state_next = S_CLEAR;
                        OP_READ: state_next = S_RD_WAIT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:      state_next = (i_reg == NW'(MAX_POINTS - 1)) ? S_OUTER : S_CLEAR;
            S_OUTER:      state_next = (i_reg >= n_reg) ? S_DONE : S_OUTER_RD;
            S_OUTER_RD:   state_next = (l_rd == LBL_UNCL) ? S_PT_RD : S_NEXT;
            S_PT_RD:      state_next = S_PT_WAIT;
            S_PT_WAIT:    state_next = S_CNT;
            S_CNT:        state_next = scan_last ? S_CNT_DRAIN : S_CNT;
            S_CNT_DRAIN:  state_next = (!v1_reg && !v2_reg) ? S_DECIDE : S_CNT_DRAIN;
            S_DECIDE:
            begin
                if (cnt_reg < minn_reg)
                    state_next = seed_reg ? S_NEXT : S_Q_RD;
                else
                    state_next = seed_reg ? S_MARK : S_GROW;
            end
            S_MARK:       state_next = scan_last ? S_MARK_DRAIN : S_MARK;
            S_MARK_DRAIN: state_next = (!v1_reg && !v2_reg) ? S_Q_RD : S_MARK_DRAIN;
            S_GROW:       state_next = scan_last ? S_GROW_DRAIN : S_GROW;
            S_GROW_DRAIN: state_next = (!v1_reg && !v2_reg) ? S_Q_RD : S_GROW_DRAIN;
            S_Q_RD:       state_next = (head_reg == tail_reg) ? S_NEXT : S_Q_WAIT;
            S_Q_WAIT:     state_next = S_PT_RD;
            S_NEXT:       state_next = S_OUTER;
            S_DONE:       state_next = out_free ? S_IDLE : S_DONE;
            S_RD_WAIT:    state_next = S_OUT;
            S_OUT:        state_next = out_free ? S_IDLE : S_OUT;
            default:      state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ch.ready = 1'b0;
        p_we = 1'b0; p_wa = in_idx[AW-1:0]; p_ra = j_reg[AW-1:0];
        l_we = 1'b0; l_wa = i_reg[AW-1:0]; l_wd = LBL_UNCL; l_ra = i_reg[AW-1:0];
        q_we = 1'b0; q_wa = tail_reg[AW-1:0]; q_ra = head_reg[AW-1:0];
        i_next = i_reg; j_next = j_reg; cur_next = cur_reg; cpt_next = cpt_reg;
        head_next = head_reg; tail_next = tail_reg; cid_next = cid_reg;
        cnt_next = cnt_reg; seed_next = seed_reg; outv_next = outv_reg;
        olbl_next = olbl_reg; occ_next = occ_reg; rdidx_next = rdidx_reg;
        rdoor_next = rdoor_reg;
        v1_next = scanning;

        if (outv_reg && out_ch.ready)
        begin
            outv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                i_next = '0;
                if (in_ch.valid)
                begin
                    case (opcode_t'(in_op))
                        OP_LOAD: p_we = (NW'(in_idx) < NW'(MAX_POINTS));
                        OP_READ:
                        begin
                            l_ra = in_idx[AW-1:0];
                            rdidx_next = in_idx[AW-1:0];
                            rdoor_next = !(NW'(in_idx) < NW'(MAX_POINTS));
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT, S_CLEAR:
            begin
                l_we = 1'b1;
                i_next = (i_reg == NW'(MAX_POINTS - 1)) ? '0 : i_reg + NW'(1);
                cid_next = '0;
            end
            S_OUTER:
            begin
                seed_next = 1'b1;
                cur_next = i_reg[AW-1:0];
            end
            S_PT_RD:
            begin
                p_ra = cur_reg;
                j_next = '0;
                cnt_next = '0;
            end
            S_PT_WAIT:
            begin
                cpt_next = p_rd;
            end
            S_CNT, S_MARK, S_GROW:
            begin
                j_next = j_reg + NW'(1);
                l_ra = j_reg[AW-1:0];
                v1_next = !scan_last;
            end
            default: ;
        endcase

        if (state_reg == S_CNT || state_reg == S_MARK || state_reg == S_GROW)
        begin
            v1_next = 1'b1;
        end
        else
        begin
            v1_next = 1'b0;
        end

        // pipeline write-back at stage 2
        if (v2_reg && hit)
        begin
            l_wa = j2_reg;
            l_wd = cid_reg;
            q_wa = tail_reg[AW-1:0];
            case (state_reg)
                S_CNT, S_CNT_DRAIN: cnt_next = cnt_reg + CntW'(1);
                S_MARK, S_MARK_DRAIN:
                begin
                    l_we = 1'b1;
                    if (j2_reg != cur_reg)
                    begin
                        q_we = 1'b1;
                        tail_next = tail_reg + NW'(1);
                    end
                end
                S_GROW, S_GROW_DRAIN:
                begin
                    if (l2_reg == LBL_UNCL)
                    begin
                        l_we = 1'b1; q_we = 1'b1;
                        tail_next = tail_reg + NW'(1);
                    end
                    else if (l2_reg == LBL_NOISE)
                    begin
                        l_we = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_DECIDE:
            begin
                j_next = '0;
                if (cnt_reg < minn_reg)
                begin
                    if (seed_reg)
                    begin
                        l_we = 1'b1; l_wa = cur_reg; l_wd = LBL_NOISE;
                    end
                end
                else if (seed_reg)
                begin
                    head_next = '0; tail_next = '0;
                end
            end
            S_MARK_DRAIN:
            begin
                if (!v1_reg && !v2_reg) seed_next = 1'b0;
            end
            S_Q_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    if (!seed_reg) cid_next = cid_reg + CntW'(1);
                end
                else
                begin
                    head_next = head_reg + NW'(1);
                end
            end
            S_Q_WAIT:
            begin
                cur_next = q_rd;
            end
            S_NEXT:
            begin
                i_next = i_reg + NW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    outv_next = 1'b1;
                    olbl_next = '0;
                    occ_next = cid_reg;
                end
            end
            S_RD_WAIT:
            begin
                l_ra = rdidx_reg;
            end
            S_OUT:
            begin
                // keep the label on the read port while the result waits
                l_ra = rdidx_reg;
                if (out_free)
                begin
                    outv_next = 1'b1;
                    olbl_next = rdoor_reg ? LBL_UNCL : l_rd;
                    occ_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid = outv_reg;
    assign out_ch.data  = {occ_reg, olbl_reg};
endmodule

// ===== design/dc3d_ram.sv =====
`timescale 1ns / 1ps
module dc3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/dc3d_dist.sv =====
`timescale 1ns / 1ps
// Two-stage neighbour test: absolute differences, then norm and compare.
module dc3d_dist
    import dc3d_pkg::*;
#(
    parameter int COORD_BITS = DefCoordBits
) (
    input  logic                      clk,
    input  logic [3*COORD_BITS-1:0]   pa,
    input  logic [3*COORD_BITS-1:0]   pb,
    input  logic [1:0]                norm,
    input  logic [ThrW-1:0]           thr,
    output logic                      hit
);
    localparam int DW = COORD_BITS + 1;
    logic [DW-1:0] d_reg [3];
    logic [DW-1:0] d_next [3];
    logic [ThrW-1:0] norm_val;
    logic [ThrW-1:0] sq [3];
    logic [DW-1:0] mx;

    always_comb
    begin
        logic signed [DW-1:0] t;
        t = '0;
        for (int k = 0; k < 3; k++)
        begin
            t = DW'($signed(pa[k*COORD_BITS +: COORD_BITS]))
              - DW'($signed(pb[k*COORD_BITS +: COORD_BITS]));
            d_next[k] = t[DW-1] ? DW'(-t) : DW'(t);
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = ThrW'(d_reg[k]) * ThrW'(d_reg[k]);
        end
        mx = d_reg[0];
        if (d_reg[1] > mx)
        begin
            mx = d_reg[1];
        end
        if (d_reg[2] > mx)
        begin
            mx = d_reg[2];
        end
        case (norm)
            NORM_L1: norm_val = ThrW'(d_reg[0]) + ThrW'(d_reg[1]) + ThrW'(d_reg[2]);
            NORM_L2: norm_val = sq[0] + sq[1] + sq[2];
            default: norm_val = ThrW'(mx);
        endcase
        hit = norm_val < thr;
    end
endmodule

// ===== design/dc3d_checker.sv =====
`timescale 1ns / 1ps
`include "density_clustering_3d_defines.svh"
module dc3d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] out_data
);
    `DC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `DC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
    `DC_ASSERT_IMPL(a_out_known, clk, rst_n, out_valid, !$isunknown(out_data))
endmodule

bind density_clustering_3d dc3d_checker u_dc3d_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import dc3d_pkg::*;

    localparam int InW = 60;
    localparam int OutW = 22;
    localparam int NPts = 1024;
    localparam int FillPts = 48;
    localparam longint CycleLimit = 3000000;

    typedef struct packed {
        logic [CntW-1:0]        clusters;
        logic signed [LblW-1:0] label;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [ThrW-1:0] cfg_data;

    dc3d_stream_if #(.W(InW)) in_ch ();
    dc3d_stream_if #(.W(OutW)) out_ch ();

    density_clustering_3d DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model of the block
    int pt_x [NPts];
    int pt_y [NPts];
    int pt_z [NPts];
    int lbl [NPts];
    int n_clusters;
    longint pcount_reg;
    longint thresh_reg;
    longint minn_reg;
    logic [1:0] norm_reg;

    result_t pending[$];
    int errors;
    int n_sent;
    int n_results;
    int n_runs;
    longint cycles;
    int snd_idle;
    int rcv_idle;
    int hold_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // receiver: random stalls, plus long holds when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            out_ch.ready = ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            n_results++;
            if (pending.size() == 0)
                report("unexpected result", got, 0);
            else
            begin
                want = pending.pop_front();
                if (got.label !== want.label)
                    report("label", got.label, want.label);
                if (got.clusters !== want.clusters)
                    report("cluster_count", got.clusters, want.clusters);
            end
        end
    end

    function automatic bit is_near(int a, int b);
        longint dx;
        longint dy;
        longint dz;
        longint span;
        dx = pt_x[a] - pt_x[b];
        dy = pt_y[a] - pt_y[b];
        dz = pt_z[a] - pt_z[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        if (norm_reg == NORM_L1)
            span = dx + dy + dz;
        else if (norm_reg == NORM_L2)
            span = dx * dx + dy * dy + dz * dz;
        else
        begin
            span = dx;
            if (dy > span) span = dy;
            if (dz > span) span = dz;
        end
        return span < thresh_reg;
    endfunction

    function automatic int neighbour_count(int p, int n);
        int c;
        c = 0;
        for (int j = 0; j < n; j++)
            if (is_near(p, j)) c++;
        return c;
    endfunction

    function automatic void cluster_points();
        int n;
        int seeds[$];
        int cur;
        n = (pcount_reg > NPts) ? NPts : int'(pcount_reg);
        for (int i = 0; i < NPts; i++) lbl[i] = LBL_UNCL;
        n_clusters = 0;
        for (int i = 0; i < n; i++)
        begin
            if (lbl[i] != LBL_UNCL) continue;
            if (neighbour_count(i, n) < minn_reg)
            begin
                lbl[i] = LBL_NOISE;
                continue;
            end
            seeds.delete();
            for (int j = 0; j < n; j++)
                if (is_near(i, j))
                begin
                    lbl[j] = n_clusters;
                    if (j != i) seeds = {seeds, j};
                end
            while (seeds.size() > 0)
            begin
                cur = seeds.pop_front();
                if (neighbour_count(cur, n) < minn_reg) continue;
                for (int j = 0; j < n; j++)
                begin
                    if (!is_near(cur, j)) continue;
                    if (lbl[j] == LBL_UNCL)
                    begin
                        seeds = {seeds, j};
                        lbl[j] = n_clusters;
                    end
                    else if (lbl[j] == LBL_NOISE)
                        lbl[j] = n_clusters;
                end
            end
            n_clusters++;
        end
    endfunction

    function automatic void predict(opcode_t op, int idx, int x, int y, int z);
        result_t r;
        case (op)
            OP_LOAD:
            begin
                pt_x[idx] = x;
                pt_y[idx] = y;
                pt_z[idx] = z;
            end
            OP_RUN:
            begin
                cluster_points();
                r.label = '0;
                r.clusters = CntW'(n_clusters);
                pending = {pending, r};
                n_runs++;
            end
            OP_READ:
            begin
                r.label = LblW'(lbl[idx]);
                r.clusters = '0;
                pending = {pending, r};
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(opcode_t op, int idx, int x = 0, int y = 0, int z = 0);
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [9:0] ci;
        cx = 16'(x);
        cy = 16'(y);
        cz = 16'(z);
        ci = 10'(idx);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid = 1'b0;
            in_ch.data = InW'({$urandom, $urandom});
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = {cz, cy, cx, ci, op};
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict(op, idx, $signed(cx), $signed(cy), $signed(cz));
        n_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // hold until every expected result is in, then let a trailing load settle
    task automatic drain();
        stop_sending();
        while (pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, longint value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = ThrW'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_POINT_COUNT: pcount_reg = value & 'h7FF;
            REG_THRESHOLD:   thresh_reg = value & 'h3_FFFF_FFFF;
            REG_MIN_NEIGH:   minn_reg = value & 'h7FF;
            default:         norm_reg = value[1:0];
        endcase
    endtask

    task automatic set_config(longint pc, longint thr, longint mn, logic [1:0] nm);
        drain();
        write_reg(REG_POINT_COUNT, pc);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_NEIGH, mn);
        write_reg(REG_NORM, nm);
    endtask

    // a coordinate near one of four cluster centres, or anywhere now and then
    function automatic int pick_coord(int centre);
        if ($urandom_range(9) == 0)
            return $signed(16'($urandom));
        return centre * 8000 - 12000 + $urandom_range(400) - 200;
    endfunction

    function automatic longint pick_threshold(logic [1:0] nm);
        case ($urandom_range(9))
            0: return 0;
            1: return 64'h3_FFFF_FFFF;
            default:
                if (nm == NORM_L1) return $urandom_range(900, 100);
                else if (nm == NORM_L2) return $urandom_range(250000, 5000);
                else return $urandom_range(400, 50);
        endcase
    endfunction

    task automatic test_directed();
        set_config(0, 0, 4, NORM_L2);
        send_item(OP_READ, 0);
        send_item(OP_READ, 1023);
        send_item(OP_NONE, 5, -1, -1, -1);
        send_item(OP_LOAD, 1023, 32767, -32768, 32767);
        send_item(OP_RUN, 0);
        send_item(OP_LOAD, 0, -32768, -32768, -32768);
        send_item(OP_LOAD, 1, 32767, 32767, 32767);
        send_item(OP_LOAD, 2, 0, 0, 0);
        send_item(OP_LOAD, 3, 3, -2, 1);
        send_item(OP_LOAD, 4, -2, 4, 0);
        send_item(OP_LOAD, 5, 1, 1, -3);
        set_config(6, 20, 3, NORM_L1);
        send_item(OP_RUN, 0);
        for (int i = 0; i < 6; i++) send_item(OP_READ, i);
        set_config(6, 64'h3_FFFF_FFFF, 0, NORM_L2);
        send_item(OP_RUN, 0);
        send_item(OP_READ, 1);
        set_config(6, 5, 2, NORM_CHEB);
        send_item(OP_RUN, 0);
        send_item(OP_READ, 3);
        set_config(6, 5, 2, NORM_SPARE);
        send_item(OP_RUN, 0);
        send_item(OP_READ, 4);
        set_config(6, 0, 1024, NORM_L1);
        send_item(OP_RUN, 0);
        send_item(OP_READ, 2);
        drain();
    endtask

    task automatic fill_store();
        int c;
        for (int i = 0; i < FillPts; i++)
        begin
            c = $urandom_range(3);
            send_item(OP_LOAD, i, pick_coord(c), pick_coord(c), pick_coord(c));
        end
    endtask

    task automatic test_random(int items, int s_idle, int r_idle);
        int done;
        int c;
        int k;
        logic [1:0] nm;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        done = 0;
        while (done < items)
        begin
            nm = 2'($urandom_range(3));
            set_config($urandom_range(FillPts, 1), pick_threshold(nm),
                       ($urandom_range(7) == 0) ? 1024 : $urandom_range(6), nm);
            for (int i = 0; i < 30; i++)
            begin
                k = $urandom_range(99);
                if (k < 30)
                begin
                    c = $urandom_range(3);
                    send_item(OP_LOAD, ($urandom_range(3) == 0) ? $urandom_range(1023)
                              : $urandom_range(FillPts - 1),
                              pick_coord(c), pick_coord(c), pick_coord(c));
                end
                else if (k < 38)
                    send_item(OP_RUN, $urandom_range(1023));
                else if (k < 95)
                    send_item(OP_READ, ($urandom_range(3) == 0) ? $urandom_range(1023)
                              : $urandom_range(FillPts - 1));
                else
                    send_item(OP_NONE, $urandom_range(1023), $urandom, $urandom, $urandom);
                done++;
            end
        end
        drain();
    endtask

    // hold the receiver while reads keep coming, so the block fills and stalls
    task automatic test_backpressure();
        snd_idle = 0;
        rcv_idle = 0;
        @(negedge clk);
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_item(OP_READ, $urandom_range(FillPts - 1));
        send_item(OP_RUN, 0);
        for (int i = 0; i < 12; i++) send_item(OP_READ, $urandom_range(FillPts - 1));
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        n_sent = 0;
        n_results = 0;
        n_runs = 0;
        cycles = 0;
        snd_idle = 0;
        rcv_idle = 0;
        hold_cycles = 0;
        for (int i = 0; i < NPts; i++)
        begin
            lbl[i] = LBL_UNCL;
            pt_x[i] = 0;
            pt_y[i] = 0;
            pt_z[i] = 0;
        end
        n_clusters = 0;
        pcount_reg = 0;
        thresh_reg = 0;
        minn_reg = 4;
        norm_reg = NORM_L2;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        fill_store();
        test_random(90, 7, 66);
        test_random(90, 66, 7);
        test_random(90, 0, 0);
        set_config(FillPts, 250000, 3, NORM_L2);
        test_backpressure();
        drain();

        $display("Sent %0d items, checked %0d results from %0d clustering runs",
                 n_sent, n_results, n_runs);
        $display("Covered all norms, threshold and neighbour extremes, stalls both sides");
        if (errors == 0 && pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
